// ===== hw/rtl/assert_macros.svh =====
// Assertion shorthands for the RTL files; included by spdc_fsm.sv.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checks that an implication holds at every clock edge outside reset.
`define SPDC_ASSERT(label, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Checks that a condition holds at every clock edge, reset included.
`define SPDC_ASSERT_ALWAYS(label, cond, msg) \
    label: assert property (@(posedge clk) cond) else $error(msg);

`endif

// ===== hw/rtl/spdc_pkg.sv =====
package spdc_pkg;

    localparam int TIMER_WIDTH = 16;
    localparam int DELTA_W     = 8;
    localparam int DUR_W       = 16;
    localparam int CFG_IDX_W   = 3;
    localparam int CFG_DATA_W  = 16;

    localparam logic signed [DELTA_W-1:0] ON_DELTA_RST  = 8'sd8;
    localparam logic signed [DELTA_W-1:0] OFF_DELTA_RST = 8'sd3;
    localparam logic [DUR_W-1:0] IDLE_MIN_RST = 16'd60;
    localparam logic [DUR_W-1:0] IDLE_MAX_RST = 16'd1440;
    localparam logic [DUR_W-1:0] PUMP_MIN_RST = 16'd1;
    localparam logic [DUR_W-1:0] PUMP_MAX_RST = 16'd600;

    typedef logic [TIMER_WIDTH-1:0] timer_t;

    typedef enum logic [2:0] {
        MODE_IDLE_MIN = 3'd0,
        MODE_IDLE     = 3'd1,
        MODE_PUMP_MIN = 3'd2,
        MODE_PUMPING  = 3'd3,
        MODE_CLEANING = 3'd4
    } mode_t;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_ON_DELTA  = 3'd0,
        CFG_OFF_DELTA = 3'd1,
        CFG_IDLE_MIN  = 3'd2,
        CFG_IDLE_MAX  = 3'd3,
        CFG_PUMP_MIN  = 3'd4,
        CFG_PUMP_MAX  = 3'd5
    } cfg_idx_t;

    typedef struct packed {
        logic signed [DELTA_W-1:0] on_delta;
        logic signed [DELTA_W-1:0] off_delta;
        logic [DUR_W-1:0]          idle_min_ticks;
        logic [DUR_W-1:0]          idle_max_ticks;
        logic [DUR_W-1:0]          pump_min_ticks;
        logic [DUR_W-1:0]          pump_max_ticks;
    } cfg_t;

    // Duration loaded into the countdown on entry to a mode.
    function automatic timer_t mode_duration(input mode_t m, input cfg_t c);
        logic [DUR_W-1:0] d;
        unique case (m)
            MODE_IDLE_MIN: d = c.idle_min_ticks;
            MODE_IDLE:     d = c.idle_max_ticks;
            MODE_PUMP_MIN: d = c.pump_min_ticks;
            default:       d = c.pump_max_ticks;
        endcase
        return TIMER_WIDTH'(d);
    endfunction

    function automatic logic mode_pumps(input mode_t m);
        return (m == MODE_PUMP_MIN) || (m == MODE_PUMPING) || (m == MODE_CLEANING);
    endfunction

endpackage

// ===== hw/rtl/spdc_if.sv =====
interface spdc_eval_if import spdc_pkg::*; ();
    logic                      valid;
    logic                      ready;
    logic                      tick;
    logic signed [DELTA_W-1:0] temp_delta;
    logic                      toggle_request;

    modport source (output valid, output tick, output temp_delta, output toggle_request,
                    input ready);
    modport sink (input valid, input tick, input temp_delta, input toggle_request,
                  output ready);
endinterface

interface spdc_result_if import spdc_pkg::*; ();
    logic        valid;
    logic        ready;
    logic        pump_on;
    logic [2:0]  mode;

    modport source (output valid, output pump_on, output mode, input ready);
    modport sink (input valid, input pump_on, input mode, output ready);
endinterface

// ===== hw/rtl/solar_pump_differential_controller_unit.sv =====
// An accepted item is held in stage s1 and moves on into the result register when that
// register is free, so a result not taken stalls s1. Throughput: one item per cycle
// while results are taken; the state update is a single combinational pass.
// Reset (rst_n, asynchronous, active low): mode idle_min, countdown 60 ticks,
// all configuration registers at their default values, both stages empty.
module solar_pump_differential_controller_unit import spdc_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  cfg_we,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data,
    spdc_eval_if.sink             eval_ch,
    spdc_result_if.source         result_ch
);

    cfg_t cfg_reg;

    logic                      s1_valid_reg;
    logic                      s1_tick_reg;
    logic signed [DELTA_W-1:0] s1_delta_reg;
    logic                      s1_toggle_reg;

    logic  res_valid_reg;
    logic  res_pump_reg;
    mode_t res_mode_reg;

    logic  res_free;
    logic  step;
    logic  take;
    mode_t mode_next;

    assign res_free      = !res_valid_reg || result_ch.ready;
    assign step          = s1_valid_reg && res_free;
    assign eval_ch.ready = !s1_valid_reg || res_free;
    assign take          = eval_ch.valid && eval_ch.ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.on_delta       <= ON_DELTA_RST;
            cfg_reg.off_delta      <= OFF_DELTA_RST;
            cfg_reg.idle_min_ticks <= IDLE_MIN_RST;
            cfg_reg.idle_max_ticks <= IDLE_MAX_RST;
            cfg_reg.pump_min_ticks <= PUMP_MIN_RST;
            cfg_reg.pump_max_ticks <= PUMP_MAX_RST;
        end
        else if (cfg_we)
        begin
            unique case (cfg_idx_t'(cfg_index))
                CFG_ON_DELTA:  cfg_reg.on_delta       <= signed'(cfg_data[DELTA_W-1:0]);
                CFG_OFF_DELTA: cfg_reg.off_delta      <= signed'(cfg_data[DELTA_W-1:0]);
                CFG_IDLE_MIN:  cfg_reg.idle_min_ticks <= cfg_data[DUR_W-1:0];
                CFG_IDLE_MAX:  cfg_reg.idle_max_ticks <= cfg_data[DUR_W-1:0];
                CFG_PUMP_MIN:  cfg_reg.pump_min_ticks <= cfg_data[DUR_W-1:0];
                CFG_PUMP_MAX:  cfg_reg.pump_max_ticks <= cfg_data[DUR_W-1:0];
                default:       ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
        end
        else if (eval_ch.ready)
        begin
            s1_valid_reg <= eval_ch.valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (take)
        begin
            s1_tick_reg   <= eval_ch.tick;
            s1_delta_reg  <= eval_ch.temp_delta;
            s1_toggle_reg <= eval_ch.toggle_request;
        end
    end

    spdc_fsm u_fsm (
        .clk            (clk),
        .rst_n          (rst_n),
        .step           (step),
        .tick           (s1_tick_reg),
        .temp_delta     (s1_delta_reg),
        .toggle_request (s1_toggle_reg),
        .cfg            (cfg_reg),
        .mode_next      (mode_next)
    );

    // The result register refills in the same cycle in which its item is taken.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            res_valid_reg <= 1'b0;
        end
        else if (res_free)
        begin
            res_valid_reg <= s1_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (step)
        begin
            res_pump_reg <= mode_pumps(mode_next);
            res_mode_reg <= mode_next;
        end
    end

    assign result_ch.valid   = res_valid_reg;
    assign result_ch.pump_on = res_pump_reg;
    assign result_ch.mode    = res_mode_reg;

endmodule

// ===== hw/rtl/spdc_fsm.sv =====
`include "assert_macros.svh"

module spdc_fsm import spdc_pkg::*;
(
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      step,
    input  logic                      tick,
    input  logic signed [DELTA_W-1:0] temp_delta,
    input  logic                      toggle_request,
    input  cfg_t                      cfg,
    output mode_t                     mode_next
);

    mode_t  mode_reg;
    timer_t countdown_reg;
    timer_t countdown_dec;
    timer_t countdown_next;
    logic   alarm;
    logic   rule_enter;
    mode_t  rule_mode;
    logic   entering;

    always_comb
    begin
        countdown_dec = countdown_reg;
        if (tick && (countdown_reg != '0))
        begin
            countdown_dec = countdown_reg - timer_t'(1);
        end
        alarm = (countdown_dec == '0);

        rule_enter = 1'b0;
        rule_mode  = mode_reg;
        unique case (mode_reg)
            MODE_IDLE_MIN:
            begin
                if (alarm)
                begin
                    rule_enter = 1'b1;
                    rule_mode  = MODE_IDLE;
                end
            end
            MODE_IDLE:
            begin
                if (temp_delta >= cfg.on_delta)
                begin
                    rule_enter = 1'b1;
                    rule_mode  = MODE_PUMP_MIN;
                end
                else if (alarm)
                begin
                    rule_enter = 1'b1;
                    rule_mode  = MODE_CLEANING;
                end
            end
            MODE_PUMP_MIN:
            begin
                if (alarm)
                begin
                    rule_enter = 1'b1;
                    rule_mode  = MODE_PUMPING;
                end
            end
            MODE_PUMPING:
            begin
                if ((temp_delta <= cfg.off_delta) || alarm)
                begin
                    rule_enter = 1'b1;
                    rule_mode  = MODE_IDLE_MIN;
                end
            end
            MODE_CLEANING:
            begin
                if (alarm)
                begin
                    rule_enter = 1'b1;
                    rule_mode  = MODE_IDLE_MIN;
                end
            end
            default:
            begin
                rule_enter = 1'b1;
                rule_mode  = MODE_IDLE_MIN;
            end
        endcase

        // The manual toggle acts on the mode left by the rule above.
        entering  = rule_enter;
        mode_next = rule_mode;
        if (toggle_request)
        begin
            entering = 1'b1;
            if ((rule_mode == MODE_IDLE_MIN) || (rule_mode == MODE_IDLE))
            begin
                mode_next = MODE_PUMP_MIN;
            end
            else
            begin
                mode_next = MODE_IDLE_MIN;
            end
        end

        countdown_next = entering ? mode_duration(mode_next, cfg) : countdown_dec;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg      <= MODE_IDLE_MIN;
            countdown_reg <= TIMER_WIDTH'(IDLE_MIN_RST);
        end
        else if (step)
        begin
            mode_reg      <= mode_next;
            countdown_reg <= countdown_next;
        end
    end

    `SPDC_ASSERT(a_hold_without_item, !step |=> $stable(mode_reg) && $stable(countdown_reg), "state moved without an item")
    `SPDC_ASSERT(a_countdown_no_rise, (step && (mode_next == mode_reg)) |=> (countdown_reg <= $past(countdown_reg)), "countdown rose without a mode change")
    `SPDC_ASSERT(a_idle_min_exit, (step && (mode_reg == MODE_IDLE_MIN) && (mode_next == MODE_IDLE)) |-> alarm, "minimum idle left before its time")

endmodule
